// ----- sv/assert_macros.svh -----
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising clock edge outside reset
`define SAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising clock edge, also during reset
`define SAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/sas_pkg.sv -----
// package for the sparse array store: sizes, payload structs, codes
package sas_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int INDEX_BITS    = 32;
    localparam int VALUE_BITS    = 64;

    localparam int ADDR_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W   = INDEX_BITS + 1;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_ENTRIES);
    localparam logic [LEN_W-1:0]   LEN_RESET  = {1'b1, {INDEX_BITS{1'b0}}};

    // register number taken from the byte address
    localparam logic REG_ARRAY_LENGTH = 1'b0;

    typedef enum logic {
        MODE_READ  = 1'b0,
        MODE_WRITE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_EXISTING = 2'd0,
        ST_CREATED  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        mode_t                  mode;
        logic [INDEX_BITS-1:0]  index;
        logic [VALUE_BITS-1:0]  write_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0]  read_value;
        status_t                status;
    } rsp_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]  index;
        logic [VALUE_BITS-1:0]  value;
    } entry_t;

endpackage

// ----- sv/sas_ram.sv -----
// generic simple dual-port ram with registered read
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/sparse_array_store.sv -----
// sparse array store: bounded (index, value) table searched in creation order
//
// requests enter on in_valid/in_stall with mode, index and write_value; one
// result leaves on out_valid/out_stall per request with read_value and status.
// a request is taken only while the engine is idle. it is registered in the
// issue state, then the scan compares the stored entries, read from the table
// ram one by one, until a hit or the last entry, and the result then moves to
// the output register. an empty table appends in the issue state and an out
// of range index is rejected there; both skip the scan.
// a hit on write or an append after a search writes the ram in the final
// compare cycle. a new request is taken in the cycle after the result moves
// to the output register. the output register holds the result while
// out_stall is high; the next request can be accepted meanwhile, and its
// result waits in the engine until the output register is free.
// array_length is written over the apb port at byte address 0 (64 bit data).
// reset empties the table (entry count zero) and sets array_length to 2^32;
// ram contents are not cleared, entries above the count are never used.
module sparse_array_store
    import sas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  req_t               in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rsp_t               out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    req_t                req_reg, req_next;
    rsp_t                res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_data_reg, out_data_next;

    logic                accept;
    logic                cfg_write;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    entry_t              ram_rdata;
    logic                hit;
    logic                last;
    logic                out_free;

    sas_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[3] == REG_ARRAY_LENGTH);

    always_comb
    begin
        prdata = '0;
        if (paddr[3] == REG_ARRAY_LENGTH)
        begin
            prdata = PDATA_W'(len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // search engine
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign hit       = (ram_rdata.index == req_reg.index);
    assign last      = ((COUNT_W'(ptr_reg) + COUNT_W'(1)) == count_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_raddr = (state_reg == S_SCAN) ? ptr_reg + ADDR_W'(1) : '0;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[ADDR_W-1:0];
        ram_wdata  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = in_data;
                    ptr_next = '0;
                    if ({1'b0, in_data.index} >= len_reg)
                    begin
                        res_next   = '{read_value: '0, status: ST_RANGE};
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        // empty table: append at once
                        ram_we          = 1'b1;
                        ram_wdata.index = in_data.index;
                        ram_wdata.value = (in_data.mode == MODE_WRITE) ?
                                          in_data.write_value : '0;
                        res_next        = '{read_value: ram_wdata.value, status: ST_CREATED};
                        count_next      = count_reg + COUNT_W'(1);
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    ram_waddr       = ptr_reg;
                    ram_wdata.index = req_reg.index;
                    ram_wdata.value = req_reg.write_value;
                    ram_we          = (req_reg.mode == MODE_WRITE);
                    res_next.read_value = (req_reg.mode == MODE_WRITE) ?
                                          req_reg.write_value : ram_rdata.value;
                    res_next.status = ST_EXISTING;
                    state_next      = S_DONE;
                end
                else if (last)
                begin
                    if (count_reg == FULL_COUNT)
                    begin
                        res_next = '{read_value: '0, status: ST_FULL};
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.index = req_reg.index;
                        ram_wdata.value = (req_reg.mode == MODE_WRITE) ?
                                          req_reg.write_value : '0;
                        res_next        = '{read_value: ram_wdata.value, status: ST_CREATED};
                        count_next      = count_reg + COUNT_W'(1);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SAS_ASSERT(a_count_bound, (count_reg <= FULL_COUNT), "entry count above table size")
    `SAS_ASSERT(a_scan_in_table, (state_reg == S_SCAN) |-> (COUNT_W'(ptr_reg) < count_reg), "scan pointer past last entry")
    `SAS_ASSERT(a_count_step, (count_reg != $past(count_reg)) |-> ((count_reg == $past(count_reg) + COUNT_W'(1)) && (res_reg.status == ST_CREATED)), "entry count changed without append")
    `SAS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (count_reg == '0), "table not empty after reset")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// testbench for sparse_array_store: directed table then random accesses, scored against a table model

module testbench;
    import sas_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int END_PAD     = 70;

    typedef struct {
        bit                 is_config;
        logic [PDATA_W-1:0] cfg_value;
        req_t               req;
        bit                 typed;
        rsp_t               result;
    } step_row_t;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    req_t               in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    rsp_t               out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [INDEX_BITS-1:0] stored_index [TABLE_ENTRIES];
    logic [VALUE_BITS-1:0] stored_value [TABLE_ENTRIES];
    int                    stored_count = 0;
    logic [LEN_W-1:0]      array_length_model = LEN_RESET;

    rsp_t                  awaited_results [$];
    logic [INDEX_BITS-1:0] index_pool [$];
    step_row_t             dir_rows [$];
    int                    mismatch_count = 0;
    int                    burst_left = 0;
    int                    cycle_count = 0;
    bit                    hold_request = 1'b0;

    sparse_array_store u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t predict_access(input req_t r);
        rsp_t res;
        res.read_value = '0;
        res.status     = ST_RANGE;
        if ({1'b0, r.index} >= array_length_model)
            return res;
        for (int k = 0; k < stored_count; k++)
        begin
            if (stored_index[k] == r.index)
            begin
                if (r.mode == MODE_WRITE)
                    stored_value[k] = r.write_value;
                res.read_value = stored_value[k];
                res.status     = ST_EXISTING;
                return res;
            end
        end
        if (stored_count >= TABLE_ENTRIES)
        begin
            res.status = ST_FULL;
            return res;
        end
        stored_index[stored_count] = r.index;
        stored_value[stored_count] = (r.mode == MODE_WRITE) ? r.write_value : '0;
        res.read_value = stored_value[stored_count];
        res.status     = ST_CREATED;
        stored_count++;
        return res;
    endfunction

    function automatic step_row_t probe_row(input mode_t m, input logic [INDEX_BITS-1:0] idx,
                                            input logic [VALUE_BITS-1:0] wv);
        step_row_t row;
        row.is_config         = 1'b0;
        row.cfg_value         = '0;
        row.req.mode          = m;
        row.req.index         = idx;
        row.req.write_value   = wv;
        row.typed             = 1'b0;
        row.result.read_value = '0;
        row.result.status     = ST_EXISTING;
        return row;
    endfunction

    function automatic step_row_t known_row(input mode_t m, input logic [INDEX_BITS-1:0] idx,
                                            input logic [VALUE_BITS-1:0] wv,
                                            input logic [VALUE_BITS-1:0] ev, input status_t es);
        step_row_t row;
        row                   = probe_row(m, idx, wv);
        row.typed             = 1'b1;
        row.result.read_value = ev;
        row.result.status     = es;
        return row;
    endfunction

    function automatic step_row_t length_row(input logic [PDATA_W-1:0] value);
        step_row_t row;
        row           = probe_row(MODE_READ, '0, '0);
        row.is_config = 1'b1;
        row.cfg_value = value;
        return row;
    endfunction

    function automatic void add_row(input step_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_length(input logic [PDATA_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ARRAY_LENGTH, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        array_length_model = value[LEN_W-1:0];
    endtask

    task automatic issue_access(input req_t r, input bit typed, input rsp_t typed_result);
        rsp_t predicted;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        predicted = predict_access(r);
        awaited_results.insert(awaited_results.size(), typed ? typed_result : predicted);
        index_pool.insert(index_pool.size(), r.index);
    endtask

    // receiver stall pattern, with one long hold on request
    initial
    begin : receiver
        int stall_pct;
        int span;
        stall_pct = 0;
        span      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (span == 0)
            begin
                span = $urandom_range(20, 120);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            span--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %h status %0d",
                             out_data.read_value, out_data.status);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (want.read_value !== out_data.read_value || want.status !== out_data.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected value %h status %0d, got value %h status %0d",
                                 want.read_value, want.status,
                                 out_data.read_value, out_data.status);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        req_t r;
        rsp_t none;
        int   pick;
        none = '0;

        // after reset: empty table, full length
        add_row(known_row(MODE_READ, 32'h0, 64'h0, 64'h0, ST_CREATED));
        add_row(known_row(MODE_WRITE, 32'h0, '1, '1, ST_EXISTING));
        add_row(known_row(MODE_WRITE, '1, 64'h8000_0000_0000_0001,
                          64'h8000_0000_0000_0001, ST_CREATED));
        add_row(probe_row(MODE_READ, '1, '1));
        add_row(known_row(MODE_WRITE, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                          64'hAAAA_AAAA_AAAA_AAAA, ST_CREATED));
        add_row(known_row(MODE_WRITE, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555,
                          64'h5555_5555_5555_5555, ST_CREATED));
        add_row(probe_row(MODE_READ, 32'hAAAA_AAAA, 64'h0));
        add_row(known_row(MODE_WRITE, 32'h0, 64'h0, 64'h0, ST_EXISTING));
        add_row(probe_row(MODE_READ, 32'h0, '1));
        add_row(probe_row(MODE_READ, 32'd12345, 64'h1234));
        // length one, then zero length
        add_row(length_row(64'd1));
        add_row(probe_row(MODE_READ, 32'h0, 64'h0));
        add_row(known_row(MODE_READ, 32'd1, 64'h0, 64'h0, ST_RANGE));
        add_row(known_row(MODE_WRITE, '1, '1, 64'h0, ST_RANGE));
        add_row(length_row(64'd0));
        add_row(known_row(MODE_READ, 32'h0, 64'h0, 64'h0, ST_RANGE));
        // bits above the register width are dropped
        add_row(length_row(64'hFFFF_FFFE_0000_0010));
        add_row(probe_row(MODE_WRITE, 32'd15, 64'hDEAD_BEEF_0123_4567));
        add_row(known_row(MODE_WRITE, 32'd16, 64'h1, 64'h0, ST_RANGE));
        add_row(length_row({31'h0, LEN_RESET}));
        add_row(probe_row(MODE_READ, '1, 64'h0));
        add_row(known_row(MODE_WRITE, 32'h8000_0000, 64'h1, 64'h1, ST_CREATED));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_config)
                write_length(dir_rows[i].cfg_value);
            else
                issue_access(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].result);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_length({31'h0, LEN_RESET});
                1: write_length(64'($urandom()) + 64'd1);
                2: write_length(64'($urandom_range(1, 64)));
                default: write_length({31'h0, LEN_RESET});
            endcase
            if (phase == 1)
                hold_request = 1'b1;
            for (int n = 0; n < 100; n++)
            begin
                r.mode = mode_t'($urandom_range(0, 1));
                pick   = $urandom_range(0, 99);
                if (pick < 55 && index_pool.size() != 0)
                    r.index = index_pool[$urandom_range(0, index_pool.size() - 1)];
                else if (pick < 75)
                    r.index = $urandom_range(0, 15);
                else if (pick < 85)
                    r.index = ($urandom_range(0, 1) != 0)
                              ? array_length_model[INDEX_BITS-1:0]
                              : array_length_model[INDEX_BITS-1:0] - 1'b1;
                else
                    r.index = $urandom();
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    r.write_value = '1;
                else if (pick == 1)
                    r.write_value = '0;
                else
                    r.write_value = {$urandom(), $urandom()};
                issue_access(r, 1'b0, none);
            end
        end

        wait_idle();
        repeat (END_PAD) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/sas_pkg.sv
sv/sas_ram.sv
sv/sparse_array_store.sv
bench/testbench.sv
